/* rtl/i2c_master_bit_sequencer_assert.svh */
// Assertion macros for the I2C master bit sequencer.
`ifndef I2C_MASTER_BIT_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_BIT_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS

`define I2CMBS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("i2cmbs assertion failed");

`define I2CMBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("i2cmbs assertion failed");

`else

`define I2CMBS_ASSERT_SAME(label, clk, rst, ante, cons)

`define I2CMBS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/i2cmbs_pkg.sv */
`timescale 1ns / 1ps

package i2cmbs_pkg;

   typedef enum logic [2:0] {
      CMD_START = 3'd0,
      CMD_STOP  = 3'd1,
      CMD_SEND  = 3'd2,
      CMD_WAIT  = 3'd3,
      CMD_READ  = 3'd4,
      CMD_IDLE  = 3'd7
   } cmd_type;

   localparam logic [7:0] ACK_RETRY_RESET = 8'd200;
   localparam logic [7:0] RETRY_MAX       = 8'hFF;
   localparam logic [3:0] BITS_PER_BYTE   = 4'd8;

   typedef struct packed {
      cmd_type    cmd;
      logic [3:0] phase;
      logic [2:0] hold;
      logic [3:0] bit_idx;
      logic [7:0] shift;
      logic [7:0] retry;
      logic       err;
      logic       scl;
      logic       sda_low;
      logic       ack;
      logic [7:0] rx;
   } state_type;

   typedef struct packed {
      logic       kind;
      logic [2:0] command;
      logic [7:0] tx_byte;
      logic       give_ack;
      logic       sda_level;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_pull_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       error_code;
   } rsp_type;

   localparam state_type STATE_RESET = '{
      cmd:     CMD_IDLE,
      phase:   4'd0,
      hold:    3'd0,
      bit_idx: 4'd0,
      shift:   8'd0,
      retry:   8'd0,
      err:     1'b0,
      scl:     1'b1,
      sda_low: 1'b0,
      ack:     1'b0,
      rx:      8'd0
   };

   function automatic logic [3:0] last_phase(input cmd_type cmd);
      logic [3:0] p;
      case (cmd)
         CMD_START, CMD_STOP: p = 4'd2;
         CMD_SEND, CMD_WAIT:  p = 4'd3;
         default:             p = 4'd5;
      endcase
      return p;
   endfunction

endpackage

/* rtl/i2cmbs_step.sv */
`timescale 1ns / 1ps

module i2cmbs_step (
   input  i2cmbs_pkg::state_type state,
   input  i2cmbs_pkg::req_type   req,
   input  logic [7:0]            retry_limit,
   output i2cmbs_pkg::state_type state_next,
   output i2cmbs_pkg::rsp_type   rsp
);

   always_comb begin
      i2cmbs_pkg::state_type s;
      logic                  enter;
      logic                  done;
      s     = state;
      enter = 1'b0;
      done  = 1'b0;

      // advance to the following step once the hold has run out
      if (s.cmd != i2cmbs_pkg::CMD_IDLE) begin
         if (s.hold == 3'd0) begin
            enter = 1'b1;
            if (s.cmd == i2cmbs_pkg::CMD_SEND && s.phase == 4'd2) begin
               s.bit_idx = s.bit_idx + 4'd1;
               s.phase   = (s.bit_idx < i2cmbs_pkg::BITS_PER_BYTE) ? 4'd0 : 4'd3;
            end else if (s.cmd == i2cmbs_pkg::CMD_READ && s.phase == 4'd1) begin
               s.bit_idx = s.bit_idx + 4'd1;
               s.phase   = (s.bit_idx < i2cmbs_pkg::BITS_PER_BYTE) ? 4'd0 : 4'd2;
            end else if (!(s.cmd == i2cmbs_pkg::CMD_WAIT && s.phase == 4'd2)) begin
               s.phase = s.phase + 4'd1;
            end
         end
      end else if (req.kind && req.command <= 3'(i2cmbs_pkg::CMD_READ)) begin
         enter     = 1'b1;
         s.cmd     = i2cmbs_pkg::cmd_type'(req.command);
         s.phase   = 4'd0;
         s.bit_idx = 4'd0;
         s.retry   = 8'd0;
         s.shift   = (req.command == 3'(i2cmbs_pkg::CMD_SEND)) ? req.tx_byte : 8'd0;
         s.ack     = req.give_ack;
      end

      // make the line changes of the entered step
      if (enter) begin
         s.hold = 3'd1;
         case (s.cmd)
            i2cmbs_pkg::CMD_START: begin
               s.hold = 3'd5;
               if (s.phase == 4'd0) begin
                  s.scl     = 1'b1;
                  s.sda_low = 1'b0;
               end else if (s.phase == 4'd1) begin
                  s.sda_low = 1'b1;
               end else begin
                  s.scl = 1'b0;
               end
            end
            i2cmbs_pkg::CMD_STOP: begin
               s.hold = 3'd5;
               if (s.phase == 4'd0) begin
                  s.scl     = 1'b0;
                  s.sda_low = 1'b1;
               end else if (s.phase == 4'd1) begin
                  s.scl = 1'b1;
               end else begin
                  s.sda_low = 1'b0;
               end
            end
            i2cmbs_pkg::CMD_SEND: begin
               if (s.phase == 4'd0) begin
                  s.scl  = 1'b0;
                  s.hold = 3'd2;
               end else if (s.phase == 4'd1) begin
                  s.sda_low = ~s.shift[7];
                  s.shift   = {s.shift[6:0], 1'b0};
                  s.hold    = 3'd2;
               end else if (s.phase == 4'd2) begin
                  s.scl  = 1'b1;
                  s.hold = 3'd5;
               end else begin
                  s.scl = 1'b0;
               end
            end
            i2cmbs_pkg::CMD_WAIT: begin
               if (s.phase == 4'd0) begin
                  s.sda_low = 1'b0;
               end else if (s.phase == 4'd1) begin
                  s.scl  = 1'b1;
                  s.hold = 3'd5;
               end else if (s.phase == 4'd2) begin
                  if (!req.sda_level) begin
                     s.phase = 4'd3;
                     s.scl   = 1'b0;
                     s.err   = 1'b0;
                  end else begin
                     if (s.retry != i2cmbs_pkg::RETRY_MAX) begin
                        s.retry = s.retry + 8'd1;
                     end
                     // no acknowledge past the retry limit: flag it and fall into the stop sequence
                     if (s.retry > retry_limit) begin
                        s.err     = 1'b1;
                        s.cmd     = i2cmbs_pkg::CMD_STOP;
                        s.phase   = 4'd0;
                        s.scl     = 1'b0;
                        s.sda_low = 1'b1;
                        s.hold    = 3'd5;
                     end
                  end
               end else begin
                  s.scl = 1'b0;
                  s.err = 1'b0;
               end
            end
            default: begin
               if (s.phase == 4'd0) begin
                  s.scl  = 1'b0;
                  s.hold = 3'd2;
               end else if (s.phase == 4'd1) begin
                  s.scl   = 1'b1;
                  s.shift = {s.shift[6:0], req.sda_level};
                  s.hold  = 3'd3;
               end else if (s.phase == 4'd2) begin
                  s.scl = 1'b0;
               end else if (s.phase == 4'd3) begin
                  s.sda_low = s.ack;
                  s.hold    = 3'd2;
               end else if (s.phase == 4'd4) begin
                  s.scl  = 1'b1;
                  s.hold = 3'd5;
               end else begin
                  s.scl = 1'b0;
                  s.err = 1'b0;
                  s.rx  = s.shift;
               end
            end
         endcase
      end

      // count down the hold and retire the command on its final tick
      if (s.cmd != i2cmbs_pkg::CMD_IDLE) begin
         if (s.hold != 3'd0) begin
            s.hold = s.hold - 3'd1;
         end
         if (s.hold == 3'd0 && s.phase == i2cmbs_pkg::last_phase(s.cmd)) begin
            done    = 1'b1;
            s.cmd   = i2cmbs_pkg::CMD_IDLE;
            s.phase = 4'd0;
         end
      end

      state_next       = s;
      rsp.scl_level    = s.scl;
      rsp.sda_pull_low = s.sda_low;
      rsp.busy_res     = (s.cmd != i2cmbs_pkg::CMD_IDLE);
      rsp.done_res     = done;
      rsp.rx_byte      = s.rx;
      rsp.error_code   = s.err;
   end

endmodule

/* rtl/i2c_master_bit_sequencer.sv */
`timescale 1ns / 1ps

// I2C master bit sequencer. Each request transaction is one 1 us tick, optionally carrying a
// new command (start, stop, send byte, wait acknowledge, read byte); each produces exactly one
// response transaction with the SCL and SDA drive levels, busy, done, the last read byte and
// the error flag after that tick. One tick is handled per clock cycle while the two-entry
// output buffer has room; the state advances in a single pass of logic and the response lands
// in that buffer, so requests keep flowing while one response waits. The acknowledge retry
// limit register may be written only while no command is running and no response is pending.
module i2c_master_bit_sequencer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   input  logic [2:0] req_command,
   input  logic [7:0] req_tx_byte,
   input  logic       req_give_ack,
   input  logic       req_sda_level,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_scl_level,
   output logic       rsp_sda_pull_low,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic [7:0] rsp_rx_byte,
   output logic       rsp_error_code,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_ack_retry_limit
);

`include "i2c_master_bit_sequencer_assert.svh"

   i2cmbs_pkg::state_type state_ff, state_in;
   i2cmbs_pkg::req_type   req;
   i2cmbs_pkg::rsp_type   rsp_new;
   i2cmbs_pkg::rsp_type   head_ff, head_in, skid_ff, skid_in;
   logic                  head_vld_ff, head_vld_in, skid_vld_ff, skid_vld_in;
   logic [7:0]            limit_ff, limit_in;
   logic                  push, pop;

   assign req.kind      = req_kind;
   assign req.command   = req_command;
   assign req.tx_byte   = req_tx_byte;
   assign req.give_ack  = req_give_ack;
   assign req.sda_level = req_sda_level;

   i2cmbs_step u_step (
      .state      (state_ff),
      .req        (req),
      .retry_limit(limit_ff),
      .state_next (state_in),
      .rsp        (rsp_new)
   );

   assign req_ready = ~skid_vld_ff;
   assign csr_ready = 1'b1;
   assign push      = req_valid & req_ready;
   assign pop       = head_vld_ff & rsp_ready;
   assign limit_in  = (csr_valid) ? csr_ack_retry_limit : limit_ff;

   always_comb begin
      head_in     = head_ff;
      skid_in     = skid_ff;
      head_vld_in = head_vld_ff;
      skid_vld_in = skid_vld_ff;
      if (pop) begin
         head_in     = skid_ff;
         head_vld_in = skid_vld_ff;
         skid_vld_in = 1'b0;
      end
      if (push) begin
         if (!head_vld_in) begin
            head_in     = rsp_new;
            head_vld_in = 1'b1;
         end else begin
            skid_in     = rsp_new;
            skid_vld_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
      if (reset) begin
         state_ff    <= i2cmbs_pkg::STATE_RESET;
         limit_ff    <= i2cmbs_pkg::ACK_RETRY_RESET;
         head_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (push) begin
            state_ff <= state_in;
         end
         limit_ff    <= limit_in;
         head_vld_ff <= head_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   assign rsp_valid        = head_vld_ff;
   assign rsp_scl_level    = head_ff.scl_level;
   assign rsp_sda_pull_low = head_ff.sda_pull_low;
   assign rsp_busy_res     = head_ff.busy_res;
   assign rsp_done_res     = head_ff.done_res;
   assign rsp_rx_byte      = head_ff.rx_byte;
   assign rsp_error_code   = head_ff.error_code;

   `I2CMBS_ASSERT_SAME(a_skid_behind_head, clock, reset, skid_vld_ff, head_vld_ff)
   `I2CMBS_ASSERT_SAME(a_done_not_busy, clock, reset, rsp_valid && rsp_done_res, !rsp_busy_res)
   `I2CMBS_ASSERT_SAME(a_idle_phase_zero, clock, reset, state_ff.cmd == i2cmbs_pkg::CMD_IDLE, state_ff.phase == 4'd0)
   `I2CMBS_ASSERT_NEXT(a_push_shows, clock, reset, push && !head_vld_ff, rsp_valid)

endmodule
